@@ sv/scg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scg_pkg
// types, widths and register codes shared by the sphere contact generator
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int CW       = 20;               // coordinate width, Q9.10
    localparam int RW       = CW - 1;           // radius and extent width
    localparam int VB       = 20;               // unit vector component width, Q1.18
    localparam int US       = 18;               // unit vector fraction bits
    localparam int GUARD    = 10;               // extra root bits for the normal
    localparam int DW       = CW + 1;           // centre difference width
    localparam int SQ_W     = 2 * DW - 1;       // one squared difference
    localparam int SUM_W    = SQ_W + 2;         // squared distance
    localparam int REM_W    = SUM_W + 2 * GUARD; // scaled squared distance
    localparam int ROOT_W   = REM_W / 2;        // root of the scaled distance
    localparam int DIST_W   = ROOT_W - GUARD;   // integer distance
    localparam int DOT_W    = DW + VB + 2;      // plane dot product
    localparam int QW       = US + 1;           // normal magnitude
    localparam int NUM_W    = DW + US + GUARD + 1; // normal dividend
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 3 * VB;
    localparam int LATENCY  = 4 + (ROOT_W + 1) + (QW + 1) + 1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PLANE_POINT    = 3'd0,
        CFG_PLANE_NORMAL   = 3'd1,
        CFG_PLANE_AXIS_U   = 3'd2,
        CFG_PLANE_AXIS_V   = 3'd3,
        CFG_PLANE_EXTENT_U = 3'd4,
        CFG_PLANE_EXTENT_V = 3'd5,
        CFG_PLANE_BOUNDED  = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic                 func;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic        [RW-1:0] first_radius;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
        logic        [RW-1:0] second_radius;
    } t_item;

    typedef struct packed {
        logic                 hit;
        logic        [CW-1:0] depth;
        logic signed [VB-1:0] normal_x;
        logic signed [VB-1:0] normal_y;
        logic signed [VB-1:0] normal_z;
        logic                 coincident;
    } t_result;

endpackage

@@ sv/sphere_contact_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_contact_generator_unit
// pipelined sphere-sphere and sphere-plane contact test
// ----------------------------------------------------------------------------
// usage
//   - one pair test is a transfer when i_start is high and o_busy is low;
//     o_busy stays low, so a new test may enter on every clock
//   - i_item.func selects sphere against sphere or sphere against the plane
//     held in the configuration registers
//   - the plane registers are written through i_cfg_we / i_cfg_index /
//     i_cfg_data while no test is in flight; unknown indexes are dropped
//   - each test gives one result on o_result, marked by o_strobe for a
//     single cycle
//   - throughput is one test per clock; the pipeline length comes from the
//     bit-serial square root (one root bit per stage, 31 stages) followed by
//     the three normal dividers (one quotient bit per stage, 19 stages)
//   - the receiver cannot stall, the pipeline never holds
//   - synchronous active-low reset clears all valid bits and sets every
//     plane register to zero
// ----------------------------------------------------------------------------
module sphere_contact_generator_unit import scg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_item             i_item,
    output logic              o_strobe,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    // side information carried along the square root stages
    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic [RW:0]              rsum;
        logic [2:0][DW-1:0]       dmag;
        logic [2:0]               dneg;
        logic                     p_hit;
        logic [CW-1:0]            p_depth;
    } t_side;

    // state of the divider stages
    typedef struct packed {
        logic                     valid;
        logic                     func;
        logic                     hit;
        logic [CW-1:0]            depth;
        logic                     coinc;
        logic [2:0]               dneg;
        logic [ROOT_W-1:0]        q;
        logic [2:0][NUM_W-1:0]    rem;
        logic [2:0][QW-1:0]       quot;
    } t_div;

    // ---------------- configuration registers ----------------
    logic [CFG_DW-1:0] r_point, r_normal, r_axis_u, r_axis_v;
    logic [RW-1:0]     r_ext_u, r_ext_v;
    logic              r_bounded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point   <= '0;
            r_normal  <= '0;
            r_axis_u  <= '0;
            r_axis_v  <= '0;
            r_ext_u   <= '0;
            r_ext_v   <= '0;
            r_bounded <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLANE_POINT:    r_point   <= i_cfg_data;
                CFG_PLANE_NORMAL:   r_normal  <= i_cfg_data;
                CFG_PLANE_AXIS_U:   r_axis_u  <= i_cfg_data;
                CFG_PLANE_AXIS_V:   r_axis_v  <= i_cfg_data;
                CFG_PLANE_EXTENT_U: r_ext_u   <= i_cfg_data[RW-1:0];
                CFG_PLANE_EXTENT_V: r_ext_v   <= i_cfg_data[RW-1:0];
                CFG_PLANE_BOUNDED:  r_bounded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // ---------------- stage 1: input register ----------------
    logic  r_s1_valid;
    t_item r_s1_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start & ~o_busy;
        end
        r_s1_item <= i_item;
    end

    // ---------------- stage 2: differences ----------------
    logic                     r_s2_valid, r_s2_func;
    logic [RW:0]              r_s2_rsum;
    logic [RW-1:0]            r_s2_r1;
    logic [2:0][DW-1:0]       r_s2_dmag;
    logic [2:0]               r_s2_dneg;
    logic signed [DW-1:0]     r_s2_p [3];

    logic signed [DW-1:0]     c1 [3];
    logic signed [DW-1:0]     c2 [3];
    logic signed [DW-1:0]     n_d [3];
    logic signed [DW-1:0]     n_p [3];

    always_comb begin
        c1[0] = DW'(r_s1_item.first_x);
        c1[1] = DW'(r_s1_item.first_y);
        c1[2] = DW'(r_s1_item.first_z);
        c2[0] = DW'(r_s1_item.second_x);
        c2[1] = DW'(r_s1_item.second_y);
        c2[2] = DW'(r_s1_item.second_z);
        for (int k = 0; k < 3; k++) begin
            n_d[k] = c1[k] - c2[k];
            n_p[k] = DW'($signed(r_point[k*VB +: VB])) - c1[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_func <= r_s1_item.func;
        r_s2_rsum <= {1'b0, r_s1_item.first_radius} + {1'b0, r_s1_item.second_radius};
        r_s2_r1   <= r_s1_item.first_radius;
        for (int k = 0; k < 3; k++) begin
            r_s2_dneg[k] <= n_d[k][DW-1];
            r_s2_dmag[k] <= n_d[k][DW-1] ? DW'(-n_d[k]) : DW'(n_d[k]);
            r_s2_p[k]    <= n_p[k];
        end
    end

    // ---------------- stage 3: products ----------------
    logic                       r_s3_valid, r_s3_func;
    logic [RW:0]                r_s3_rsum;
    logic [RW-1:0]              r_s3_r1;
    logic [2:0][DW-1:0]         r_s3_dmag;
    logic [2:0]                 r_s3_dneg;
    logic [SQ_W-1:0]            r_s3_sq [3];
    logic signed [DW+VB-1:0]    r_s3_pn [3];
    logic signed [DW+VB-1:0]    r_s3_pu [3];
    logic signed [DW+VB-1:0]    r_s3_pv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_func <= r_s2_func;
        r_s3_rsum <= r_s2_rsum;
        r_s3_r1   <= r_s2_r1;
        r_s3_dmag <= r_s2_dmag;
        r_s3_dneg <= r_s2_dneg;
        for (int k = 0; k < 3; k++) begin
            r_s3_sq[k] <= SQ_W'(r_s2_dmag[k]) * SQ_W'(r_s2_dmag[k]);
            r_s3_pn[k] <= r_s2_p[k] * $signed(r_normal[k*VB +: VB]);
            r_s3_pu[k] <= r_s2_p[k] * $signed(r_axis_u[k*VB +: VB]);
            r_s3_pv[k] <= r_s2_p[k] * $signed(r_axis_v[k*VB +: VB]);
        end
    end

    // ---------------- stage 4: sums and magnitudes ----------------
    logic                   r_s4_valid, r_s4_func;
    logic [RW:0]            r_s4_rsum;
    logic [RW-1:0]          r_s4_r1;
    logic [2:0][DW-1:0]     r_s4_dmag;
    logic [2:0]             r_s4_dneg;
    logic [SUM_W-1:0]       r_s4_s;
    logic [DOT_W-1:0]       r_s4_an, r_s4_au, r_s4_av;

    logic signed [DOT_W-1:0] n_dn, n_du, n_dv;

    always_comb begin
        n_dn = DOT_W'(r_s3_pn[0]) + DOT_W'(r_s3_pn[1]) + DOT_W'(r_s3_pn[2]);
        n_du = DOT_W'(r_s3_pu[0]) + DOT_W'(r_s3_pu[1]) + DOT_W'(r_s3_pu[2]);
        n_dv = DOT_W'(r_s3_pv[0]) + DOT_W'(r_s3_pv[1]) + DOT_W'(r_s3_pv[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_func <= r_s3_func;
        r_s4_rsum <= r_s3_rsum;
        r_s4_r1   <= r_s3_r1;
        r_s4_dmag <= r_s3_dmag;
        r_s4_dneg <= r_s3_dneg;
        r_s4_s    <= SUM_W'(r_s3_sq[0]) + SUM_W'(r_s3_sq[1]) + SUM_W'(r_s3_sq[2]);
        r_s4_an   <= n_dn[DOT_W-1] ? DOT_W'(-n_dn) : DOT_W'(n_dn);
        r_s4_au   <= n_du[DOT_W-1] ? DOT_W'(-n_du) : DOT_W'(n_du);
        r_s4_av   <= n_dv[DOT_W-1] ? DOT_W'(-n_dv) : DOT_W'(n_dv);
    end

    // ---------------- square root, one root bit per stage ----------------
    // plane decision is settled on entry and rides along
    t_side             r_sq_side [ROOT_W+1];
    logic [REM_W-1:0]  r_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W+1];

    t_side            n_side0;
    logic [DOT_W-1:0] p_dist;
    logic             p_inside, p_close;

    always_comb begin
        p_dist   = r_s4_an >> US;
        p_close  = (DOT_W'(r_s4_r1) << US) > r_s4_an;
        p_inside = !r_bounded ||
                   ((r_s4_au < (DOT_W'(r_ext_u) << US)) &&
                    (r_s4_av < (DOT_W'(r_ext_v) << US)));
        n_side0.valid   = r_s4_valid;
        n_side0.func    = r_s4_func;
        n_side0.rsum    = r_s4_rsum;
        n_side0.dmag    = r_s4_dmag;
        n_side0.dneg    = r_s4_dneg;
        n_side0.p_hit   = p_close && p_inside;
        n_side0.p_depth = CW'(r_s4_r1 - p_dist[RW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_side[0].valid <= 1'b0;
        end else begin
            r_sq_side[0].valid <= n_side0.valid;
        end
        r_sq_side[0][$bits(t_side)-2:0] <= n_side0[$bits(t_side)-2:0];
        r_sq_rem[0]  <= {r_s4_s, {(2*GUARD){1'b0}}};
        r_sq_root[0] <= '0;
    end

    for (genvar gk = 1; gk <= ROOT_W; gk++) begin : g_sqrt
        localparam int BIT = ROOT_W - gk;
        logic [REM_W-1:0]  n_trial;
        logic              n_take;

        always_comb begin
            n_trial = (REM_W'(r_sq_root[gk-1]) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
            n_take  = r_sq_rem[gk-1] >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[gk].valid <= 1'b0;
            end else begin
                r_sq_side[gk].valid <= r_sq_side[gk-1].valid;
            end
            r_sq_side[gk][$bits(t_side)-2:0] <= r_sq_side[gk-1][$bits(t_side)-2:0];
            r_sq_rem[gk]  <= n_take ? r_sq_rem[gk-1] - n_trial : r_sq_rem[gk-1];
            r_sq_root[gk] <= r_sq_root[gk-1] | (n_take ? ROOT_W'(1) << BIT : '0);
        end
    end

    // ---------------- contact decision and normal dividers ----------------
    t_div r_dv [QW+1];

    t_side            sq_last;
    logic [ROOT_W-1:0] q_root;
    logic [DIST_W-1:0] s_dist;
    logic              s_hit;
    t_div              n_dv0;

    always_comb begin
        sq_last = r_sq_side[ROOT_W];
        q_root  = r_sq_root[ROOT_W];
        s_dist  = DIST_W'(q_root >> GUARD);
        s_hit   = DIST_W'(sq_last.rsum) > s_dist;
        n_dv0.valid = sq_last.valid;
        n_dv0.func  = sq_last.func;
        n_dv0.hit   = sq_last.func ? sq_last.p_hit : s_hit;
        n_dv0.depth = sq_last.func ? sq_last.p_depth
                                   : CW'(DIST_W'(sq_last.rsum) - s_dist);
        n_dv0.coinc = q_root == '0;
        n_dv0.dneg  = sq_last.dneg;
        n_dv0.q     = q_root;
        for (int k = 0; k < 3; k++) begin
            n_dv0.rem[k]  = (NUM_W'(sq_last.dmag[k]) << (US + GUARD)) +
                            NUM_W'(q_root >> 1);
            n_dv0.quot[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else begin
            r_dv[0].valid <= n_dv0.valid;
        end
        r_dv[0][$bits(t_div)-2:0] <= n_dv0[$bits(t_div)-2:0];
    end

    for (genvar gj = 1; gj <= QW; gj++) begin : g_div
        localparam int BIT = QW - gj;
        logic [NUM_W-1:0] n_dsh;
        t_div             n_next;

        always_comb begin
            n_dsh  = NUM_W'(r_dv[gj-1].q) << BIT;
            n_next = r_dv[gj-1];
            for (int k = 0; k < 3; k++) begin
                if (r_dv[gj-1].rem[k] >= n_dsh) begin
                    n_next.rem[k]       = r_dv[gj-1].rem[k] - n_dsh;
                    n_next.quot[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gj].valid <= 1'b0;
            end else begin
                r_dv[gj].valid <= n_next.valid;
            end
            r_dv[gj][$bits(t_div)-2:0] <= n_next[$bits(t_div)-2:0];
        end
    end

    // ---------------- output register ----------------
    t_div    dv_last;
    t_result n_result;
    logic signed [VB-1:0] n_nrm [3];

    always_comb begin
        dv_last = r_dv[QW];
        for (int k = 0; k < 3; k++) begin
            if (!dv_last.hit) begin
                n_nrm[k] = '0;
            end else if (dv_last.func) begin
                n_nrm[k] = $signed(r_normal[k*VB +: VB]);
            end else if (dv_last.coinc) begin
                n_nrm[k] = '0;
            end else begin
                n_nrm[k] = dv_last.dneg[k] ? -$signed(VB'(dv_last.quot[k]))
                                           : $signed(VB'(dv_last.quot[k]));
            end
        end
        n_result.hit        = dv_last.hit;
        n_result.depth      = dv_last.hit ? dv_last.depth : '0;
        n_result.normal_x   = n_nrm[0];
        n_result.normal_y   = n_nrm[1];
        n_result.normal_z   = n_nrm[2];
        n_result.coincident = dv_last.hit && !dv_last.func && dv_last.coinc;
    end

    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= dv_last.valid;
        end
        r_out <= n_result;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // a miss reports nothing but the miss
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.hit |->
            o_result.depth == '0 && o_result.normal_x == '0 &&
            o_result.normal_y == '0 && o_result.normal_z == '0 &&
            !o_result.coincident)
        else $error("miss with nonzero payload");

    // coincident centres give a hit with a zero normal
    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.coincident |->
            o_result.hit && o_result.normal_x == '0 &&
            o_result.normal_y == '0 && o_result.normal_z == '0)
        else $error("coincident result with nonzero normal");

    // every accepted test comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##LATENCY o_strobe)
        else $error("result missing after pipeline latency");

    // no result without a test accepted at the matching time
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, LATENCY))
        else $error("result without matching input transfer");
`endif

endmodule

@@ test/sphere_contact_generator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_contact_generator_unit_tb
// drives pair tests in sphere and plane mode under several plane settings,
// predicts each contact in exact fixed point and checks every result
// ----------------------------------------------------------------------------
module sphere_contact_generator_unit_tb;
    import scg_pkg::*;

    localparam int ITEM_W = $bits(t_item);

    // contact prediction and the queue of pending contacts
    class contact_board;
        t_result   pending[$];
        logic [59:0] pt = '0, nv = '0, ua = '0, va = '0;
        logic [RW-1:0] ext_u = '0, ext_v = '0;
        logic        bounded = 1'b0;
        int          errors;

        function void set_reg(t_cfg_index idx, logic [CFG_DW-1:0] d);
            case (idx)
                CFG_PLANE_POINT:    pt = d;
                CFG_PLANE_NORMAL:   nv = d;
                CFG_PLANE_AXIS_U:   ua = d;
                CFG_PLANE_AXIS_V:   va = d;
                CFG_PLANE_EXTENT_U: ext_u = d[RW-1:0];
                CFG_PLANE_EXTENT_V: ext_v = d[RW-1:0];
                CFG_PLANE_BOUNDED:  bounded = d[0];
                default: ;
            endcase
        endfunction

        function longint unsigned absdot(longint p[3], logic [59:0] v);
            longint s;
            s = 0;
            for (int k = 0; k < 3; k++)
                s += p[k] * longint'($signed(v[k*20 +: 20]));
            return (s < 0) ? -s : s;
        endfunction

        function void note_item(t_item it);
            t_result r;
            longint  c[3], d[3], p[3];
            logic [127:0] s, q, t, m;
            longint unsigned rs, span;
            r = '0;
            c[0] = longint'(it.first_x);
            c[1] = longint'(it.first_y);
            c[2] = longint'(it.first_z);
            if (!it.func) begin
                d[0] = c[0] - longint'(it.second_x);
                d[1] = c[1] - longint'(it.second_y);
                d[2] = c[2] - longint'(it.second_z);
                s = '0;
                for (int k = 0; k < 3; k++) s += 128'(d[k] * d[k]);
                s = s << 20;
                q = '0;
                for (int i = 63; i >= 0; i--) begin
                    t = q | (128'd1 << i);
                    if (t * t <= s) q = t;
                end
                span = 64'(q >> GUARD);
                rs = longint'(it.first_radius) + longint'(it.second_radius);
                if (rs > span) begin
                    r.hit = 1'b1;
                    r.depth = CW'(rs - span);
                    if (q == 0) r.coincident = 1'b1;
                    else begin
                        for (int k = 0; k < 3; k++) begin
                            m = ((128'(d[k] < 0 ? -d[k] : d[k]) << 28) + q / 2) / q;
                            if (d[k] < 0) m = -m;
                            case (k)
                                0: r.normal_x = m[19:0];
                                1: r.normal_y = m[19:0];
                                default: r.normal_z = m[19:0];
                            endcase
                        end
                    end
                end
            end else begin
                for (int k = 0; k < 3; k++) p[k] = longint'($signed(pt[k*20 +: 20])) - c[k];
                span = absdot(p, nv) >> US;
                if (longint'(it.first_radius) > span &&
                    (!bounded || (absdot(p, ua) < (longint'(ext_u) << US) &&
                                  absdot(p, va) < (longint'(ext_v) << US)))) begin
                    r.hit = 1'b1;
                    r.depth = CW'(longint'(it.first_radius) - span);
                    r.normal_x = nv[19:0];
                    r.normal_y = nv[39:20];
                    r.normal_z = nv[59:40];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10) $display("mismatch exp %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_we = 0;
    logic               o_busy, o_strobe;
    t_item              i_item = '0;
    t_result            o_result;
    logic [CFG_AW-1:0]  i_cfg_index = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;
    contact_board       board = new();
    bit                 calm;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    sphere_contact_generator_unit i_dut (.*);

    // every strobed result is a transfer
    always @(posedge i_clk)
        if (i_rst_n && o_strobe) board.check_result(o_result);

    // one register write, after which the write enable is taken low again
    task automatic write_reg(t_cfg_index idx, logic [CFG_DW-1:0] d);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        board.set_reg(idx, d);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // one pair test, with random idle cycles before it unless calm
    task automatic send_item(t_item it);
        while (!calm && $urandom_range(99) < 34) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_item(it);
    endtask

    task automatic drain();
        i_start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [59:0] unit_vec(int axis, bit neg);
        logic [19:0] one;
        one = neg ? -20'sd262144 : 20'sd262144;
        return 60'(one) << (axis * 20);
    endfunction

    function automatic t_item rand_item(bit near);
        t_item it;
        it = t_item'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        if (near) begin
            it.first_x = CW'($signed($urandom_range(8000)) - 4000);
            it.first_y = CW'($signed($urandom_range(8000)) - 4000);
            it.first_z = CW'($signed($urandom_range(8000)) - 4000);
            it.second_x = CW'(it.first_x + $signed($urandom_range(6000)) - 3000);
            it.second_y = CW'(it.first_y + $signed($urandom_range(6000)) - 3000);
            it.second_z = CW'(it.first_z + $signed($urandom_range(6000)) - 3000);
            it.first_radius  = RW'($urandom_range(4000));
            it.second_radius = RW'($urandom_range(4000));
        end
        return it;
    endfunction

    initial begin
        #4000000;
        $display("sphere_contact_generator_unit_tb: FAIL");
        $finish;
    end

    initial begin
        t_item it;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes and special cases with the plane at reset
        it = '0; send_item(it);                      // coincident, zero radii
        it.first_radius = 19'd5; send_item(it);      // coincident with contact
        it = '0; it.first_x = 20'sh80000; it.first_y = 20'sh80000; it.first_z = 20'sh80000;
        it.second_x = 20'sh7ffff; it.second_y = 20'sh7ffff; it.second_z = 20'sh7ffff;
        it.first_radius = '1; it.second_radius = '1; send_item(it);
        it.first_x = 20'sh7ffff; it.second_x = 20'sh80000; send_item(it);
        it = '0; it.first_x = 20'sd1000; it.first_radius = 19'd600;
        it.second_radius = 19'd600;
        send_item(it);
        it.first_radius = 19'd400; send_item(it);    // just short
        it.func = 1'b1; it.first_radius = 19'd10; send_item(it);
        drain();

        write_reg(CFG_PLANE_NORMAL, unit_vec(2, 0));
        write_reg(CFG_PLANE_AXIS_U, unit_vec(0, 0));
        write_reg(CFG_PLANE_AXIS_V, unit_vec(1, 0));
        write_reg(CFG_PLANE_EXTENT_U, '1);
        write_reg(CFG_PLANE_EXTENT_V, 60'd3000);
        write_reg(CFG_PLANE_POINT, {20'sd500, 20'sd0, 20'sd0});
        write_reg(CFG_PLANE_BOUNDED, 60'd1);
        it = '0; it.func = 1'b1; it.first_z = '0; it.first_radius = 19'd600; send_item(it);
        it.first_radius = 19'd500; send_item(it);    // touching only
        it.first_y = 20'sd3000; it.first_radius = 19'd600; send_item(it); // on the edge
        it.first_y = 20'sd2999; send_item(it);
        it.first_x = 20'sh80000; it.first_radius = '1; send_item(it);
        it.first_z = 20'sh7ffff; send_item(it);
        drain();

        // random phases over several plane settings
        for (int ph = 0; ph < 6; ph++) begin
            logic [19:0] n[3];
            if (ph == 5) begin
                write_reg(CFG_PLANE_POINT, 60'({$urandom, $urandom}));
                write_reg(CFG_PLANE_NORMAL, 60'({$urandom, $urandom}));
                write_reg(CFG_PLANE_AXIS_U, 60'({$urandom, $urandom}));
                write_reg(CFG_PLANE_AXIS_V, 60'({$urandom, $urandom}));
            end else begin
                n[0] = ($urandom_range(1) ? 20'sd185364 : -20'sd185364);
                write_reg(CFG_PLANE_POINT, {20'($signed($urandom_range(4000)) - 2000),
                                            20'($signed($urandom_range(4000)) - 2000),
                                            20'($signed($urandom_range(4000)) - 2000)});
                write_reg(CFG_PLANE_NORMAL, ph[0] ? {n[0], 20'sd0, n[0]} :
                                                    unit_vec(ph % 3, ph[1]));
                write_reg(CFG_PLANE_AXIS_U, unit_vec((ph + 1) % 3, ph[0]));
                write_reg(CFG_PLANE_AXIS_V, unit_vec((ph + 2) % 3, ph[1]));
            end
            write_reg(CFG_PLANE_EXTENT_U, ph == 4 ? '0 : 60'($urandom_range(5000)));
            write_reg(CFG_PLANE_EXTENT_V, ph == 3 ? '1 : 60'($urandom_range(5000)));
            write_reg(CFG_PLANE_BOUNDED, 60'(ph % 2));
            write_reg(t_cfg_index'(7), 60'($urandom));    // unused index, dropped
            for (int i = 0; i < 215; i++) begin
                calm = (ph == 2 && i >= 50 && i < 150);
                it = rand_item($urandom_range(99) < 80);
                send_item(it);
                if (ph == 1 && i == 100) drain();    // let the pipeline empty
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("sphere_contact_generator_unit_tb: PASS");
        else
            $display("sphere_contact_generator_unit_tb: FAIL");
        $finish;
    end
endmodule
